// File: sv/slm_pkg.sv
// Shared constants, codes and control types of the sorted list merge block.
`default_nettype none
package slm_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int VAL_W      = 8;
    localparam int OP_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_FIRST  = 2'd0,
        OP_SECOND = 2'd1,
        OP_MERGE  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } t_state;

    typedef struct packed {
        logic load_en;
        logic walk_en;
    } t_slm_cmd;

    typedef struct packed {
        logic start_acc;
        logic last_emit;
    } t_slm_status;

endpackage
`default_nettype wire

// File: sv/slm_ctrl.sv
// Controller state machine: load phase and merge walk.
`default_nettype none
module slm_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire slm_pkg::t_slm_status i_status,
    output slm_pkg::t_slm_cmd         o_cmd
);

    slm_pkg::t_state r_state;
    slm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            slm_pkg::ST_IDLE: begin
                if (i_status.start_acc) n_state = slm_pkg::ST_MERGE;
            end
            slm_pkg::ST_MERGE: begin
                if (i_status.last_emit) n_state = slm_pkg::ST_IDLE;
            end
            default: n_state = slm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            slm_pkg::ST_IDLE:  o_cmd.load_en = 1'b1;
            slm_pkg::ST_MERGE: o_cmd.walk_en = 1'b1;
            default:           o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/slm_datapath.sv
// Datapath: list stores, counts, merge pointers and the output register.
`default_nettype none
module slm_datapath (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire slm_pkg::t_slm_cmd     i_cmd,
    output slm_pkg::t_slm_status       o_status,
    input  wire                        i_s_tvalid,
    output logic                       o_s_tready,
    input  wire [slm_pkg::VAL_W-1:0]   i_s_tdata,
    input  wire [slm_pkg::OP_W-1:0]    i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire                        i_m_tready,
    output logic [slm_pkg::VAL_W-1:0]  o_m_tdata,
    output logic                       o_m_tlast,
    output logic [1:0]                 o_m_tuser
);

    localparam logic [slm_pkg::CNT_W-1:0] FULL = slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH);

    logic [slm_pkg::VAL_W-1:0] r_first  [slm_pkg::LIST_DEPTH];
    logic [slm_pkg::VAL_W-1:0] r_second [slm_pkg::LIST_DEPTH];
    logic [slm_pkg::CNT_W-1:0] r_first_cnt, r_second_cnt;
    logic [slm_pkg::CNT_W-1:0] r_i, r_j;
    logic                      r_dropped;

    logic                      r_out_valid;
    logic [slm_pkg::VAL_W-1:0] r_out_value;
    logic                      r_out_last;
    logic                      r_out_empty;
    logic                      r_out_ovf;

    logic                      accept;
    slm_pkg::t_opcode          op;
    logic                      out_ok;
    logic                      emit;
    logic                      take_first;
    logic                      is_final;
    logic                      list_empty;
    logic [slm_pkg::CNT_W:0]   total;
    logic [slm_pkg::CNT_W:0]   taken_next;
    logic [slm_pkg::VAL_W-1:0] head_first, head_second;
    logic [slm_pkg::VAL_W-1:0] pick;

    assign o_s_tready = i_cmd.load_en;
    assign accept     = i_s_tvalid && o_s_tready;
    assign op         = slm_pkg::t_opcode'(i_s_tuser);

    assign head_first  = r_first[r_i[slm_pkg::IDX_W-1:0]];
    assign head_second = r_second[r_j[slm_pkg::IDX_W-1:0]];

    assign total      = {1'b0, r_first_cnt} + {1'b0, r_second_cnt};
    assign taken_next = {1'b0, r_i} + {1'b0, r_j} + (slm_pkg::CNT_W+1)'(1);
    assign list_empty = (total == '0);
    // Once the total is known to be nonzero, the final pick is the one that uses it up.
    assign is_final   = list_empty || (taken_next == total);

    assign take_first = (r_i < r_first_cnt) &&
                        ((r_j >= r_second_cnt) || (head_first <= head_second));
    assign pick       = list_empty ? '0 : (take_first ? head_first : head_second);

    assign out_ok = !r_out_valid || i_m_tready;
    assign emit   = i_cmd.walk_en && out_ok;

    assign o_status.start_acc = accept && (op == slm_pkg::OP_MERGE);
    assign o_status.last_emit = emit && is_final;

    always_ff @(posedge i_clk) begin
        if (accept && (op == slm_pkg::OP_FIRST) && (r_first_cnt < FULL)) begin
            r_first[r_first_cnt[slm_pkg::IDX_W-1:0]] <= i_s_tdata;
        end
        if (accept && (op == slm_pkg::OP_SECOND) && (r_second_cnt < FULL)) begin
            r_second[r_second_cnt[slm_pkg::IDX_W-1:0]] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_dropped    <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
        end else if (emit) begin
            if (is_final) begin
                r_first_cnt  <= '0;
                r_second_cnt <= '0;
                r_dropped    <= 1'b0;
                r_i          <= '0;
                r_j          <= '0;
            end else if (take_first) begin
                r_i <= r_i + slm_pkg::CNT_W'(1);
            end else begin
                r_j <= r_j + slm_pkg::CNT_W'(1);
            end
        end else if (accept) begin
            case (op)
                slm_pkg::OP_FIRST: begin
                    if (r_first_cnt < FULL) r_first_cnt <= r_first_cnt + slm_pkg::CNT_W'(1);
                    else                    r_dropped   <= 1'b1;
                end
                slm_pkg::OP_SECOND: begin
                    if (r_second_cnt < FULL) r_second_cnt <= r_second_cnt + slm_pkg::CNT_W'(1);
                    else                     r_dropped    <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value <= pick;
            r_out_last  <= is_final;
            r_out_empty <= list_empty;
            r_out_ovf   <= r_dropped;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_ovf, r_out_empty};

endmodule
`default_nettype wire

// File: sv/sorted_list_merge_core.sv
// An element request is stored when it is accepted. An accepted start request moves the
// controller to its merge state, and each result is then registered in the output register.
// The walk registers one result per cycle while the output is not stalled, so a merge
// of n elements gives max(n, 1) results and holds off input until its last result is
// registered; each element is loaded by its own request, and an output stall holds the walk.
// Synchronous active-low reset empties both lists, clears the overflow flag and drops
// any pending result; list contents are not cleared.
`default_nettype none
module sorted_list_merge_core (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_tvalid,
    output logic                       o_s_tready,
    input  wire [slm_pkg::VAL_W-1:0]   i_s_tdata,   // element_value
    input  wire [slm_pkg::OP_W-1:0]    i_s_tuser,   // opcode
    output logic                       o_m_tvalid,
    input  wire                        i_m_tready,
    output logic [slm_pkg::VAL_W-1:0]  o_m_tdata,   // merged_value
    output logic                       o_m_tlast,
    output logic [1:0]                 o_m_tuser    // overflow, empty_res
);

    slm_pkg::t_slm_cmd    cmd;
    slm_pkg::t_slm_status status;

    slm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    slm_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire

// File: sv/slm_checker.sv
// Port-level checker for the sorted list merge core, bound to the top level.
`default_nettype none
module slm_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_s_tvalid,
    input wire                       o_s_tready,
    input wire [slm_pkg::OP_W-1:0]   i_s_tuser,
    input wire                       o_m_tvalid,
    input wire                       i_m_tready,
    input wire [slm_pkg::VAL_W-1:0]  o_m_tdata,
    input wire                       o_m_tlast,
    input wire [1:0]                 o_m_tuser
);

    // The empty-merge result is always the single, final result with a zero value.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tlast && (o_m_tdata == '0)))
        else $error("empty result without last or with nonzero value");

    // While a merge still has results to give, no new request is taken.
    a_no_load_mid_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input ready in the middle of a merge");

    // An accepted start closes the input; this assertion checks it right after the start is taken.
    a_start_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == slm_pkg::OP_MERGE)) |=> !o_s_tready)
        else $error("input still ready after a start request");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    a_reset_no_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind sorted_list_merge_core slm_checker u_slm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
